### sv/crcc_pkg.sv
// Package for the chunk reassembly and CRC check block.
// Holds the request and result structs, status and mode codes, and the CRC-32 byte step.
// No dependencies.
`timescale 1ns / 1ps

package crcc_pkg;

  // Request modes
  localparam logic [1:0] MODE_META  = 2'd0;
  localparam logic [1:0] MODE_CHUNK = 2'd1;
  localparam logic [1:0] MODE_DONE  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  // Result status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_BAD_VERSION = 4'd1;
  localparam logic [3:0] ST_REPLACED    = 4'd2;
  localparam logic [3:0] ST_TOO_LARGE   = 4'd3;
  localparam logic [3:0] ST_ORPHAN      = 4'd4;
  localparam logic [3:0] ST_RANGE       = 4'd5;
  localparam logic [3:0] ST_CRC_OK      = 4'd6;
  localparam logic [3:0] ST_CRC_BAD     = 4'd7;
  localparam logic [3:0] ST_INCOMPLETE  = 4'd8;
  localparam logic [3:0] ST_IDLE_DONE   = 4'd9;

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [7:0] LINK_VERSION_RST = 8'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  version;
    logic [31:0] file_id;
    logic [31:0] file_bytes;
    logic [15:0] chunk_count;
    logic [31:0] expected_crc;
    logic [15:0] chunk_index;
    logic [7:0]  chunk_length;
    logic [7:0]  byte_offset;
    logic [7:0]  data_byte;
    logic        chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] computed_crc;
    logic [31:0] current_file;
    logic [15:0] chunks_seen;
    logic [15:0] chunks_announced;
  } out_item_t;

  // Control from the sequencer to the CRC unit
  typedef struct packed {
    logic       init;
    logic       step;
    logic [7:0] data;
  } crc_ctrl_t;

  // Fold one byte into the running CRC, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/crcc_crc_unit.sv
// CRC-32 accumulator: folds one buffer byte per cycle under sequencer control.
// Depends on crcc_pkg.
`timescale 1ns / 1ps

module crcc_crc_unit (
  input  logic                  clk,
  input  crcc_pkg::crc_ctrl_t   ctrl,
  output logic [31:0]           crc
);
  import crcc_pkg::*;

  logic [31:0] crc_r;
  logic [31:0] crc_nxt;

  // Seed, step or hold
  always_comb begin
    crc_nxt = crc_r;
    if (ctrl.init) begin
      crc_nxt = CRC_INIT;
    end else if (ctrl.step) begin
      crc_nxt = crc_byte(crc_r, ctrl.data);
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  // Final inversion
  assign crc = ~crc_r;

endmodule

### sv/chunk_reassembly_crc_check.sv
// Top level of the chunk reassembly block: sequencer, transfer state and file buffer.
// Depends on crcc_pkg and crcc_crc_unit.
`timescale 1ns / 1ps

// Usage
//   in_*  : one request per handshake (meta, chunk byte, done, or no-op).
//   out_* : exactly one result per request, in order.
//   cfg_* : writes link_version; always ready, write only while the block is idle.
// Sequence
//   A request is taken in the idle state, then passes through S_MUL, forming the chunk
//   base address (the one multiplier), S_EXEC, deciding and writing the buffer, and
//   S_OUT, loading the output register.
//   A done on a complete transfer also walks the buffer through the CRC unit,
//   one byte per cycle off the buffer's single read port.
//   in_ready is low while a request is in work.
// Reset
//   rst_n (synchronous, active low) closes any transfer, clears the counters and
//   sets link_version to 1. The buffer is not cleared; bytes not written in the
//   current transfer give an undefined CRC.
// Stall
//   The result sits in the output register until out_ready. A request finishing
//   while that register is full waits in its final state; no result is dropped.
module chunk_reassembly_crc_check #(
  parameter int BUFFER_BYTES = 65536,
  parameter int CHUNK_BYTES  = 240
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  crcc_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output crcc_pkg::out_item_t   out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);
  import crcc_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int SW = $clog2(BUFFER_BYTES + 1);
  localparam int CW = $clog2(CHUNK_BYTES + 1);
  localparam int BW = 16 + CW;
  localparam int XW = (BW + 1 > SW) ? BW + 1 : SW;
  localparam logic [BW-1:0] CHUNK_K   = BW'(CHUNK_BYTES);
  localparam logic [32:0]   BUF_LIMIT = 33'(BUFFER_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_CRC  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  in_item_t      item_r;
  logic [BW-1:0] base_r;
  logic [7:0]    link_version_r;
  logic          open_r, open_nxt;
  logic [31:0]   open_file_r, open_file_nxt;
  logic [SW-1:0] open_size_r, open_size_nxt;
  logic [15:0]   announced_r, announced_nxt;
  logic [15:0]   received_r, received_nxt;
  logic [31:0]   sender_crc_r, sender_crc_nxt;
  logic [SW-1:0] rd_addr_r, rd_addr_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [7:0]    rd_data_r;
  logic [3:0]    res_status_r, res_status_nxt;
  logic [31:0]   res_crc_r, res_crc_nxt;
  out_item_t     out_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    mem [BUFFER_BYTES];

  logic          mem_we;
  logic [XW-1:0] chunk_end_addr;
  logic [XW-1:0] wr_addr;
  logic          out_load;
  logic [31:0]   crc_value;
  crc_ctrl_t     crc_ctrl;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign chunk_end_addr = XW'(base_r) + XW'(item_r.chunk_length);
  assign wr_addr        = XW'(base_r) + XW'(item_r.byte_offset);
  assign out_load       = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Sequencer and transfer state
  always_comb begin
    state_nxt      = state_r;
    open_nxt       = open_r;
    open_file_nxt  = open_file_r;
    open_size_nxt  = open_size_r;
    announced_nxt  = announced_r;
    received_nxt   = received_r;
    sender_crc_nxt = sender_crc_r;
    rd_addr_nxt    = rd_addr_r;
    rd_pend_nxt    = 1'b0;
    res_status_nxt = res_status_r;
    res_crc_nxt    = res_crc_r;
    mem_we         = 1'b0;
    crc_ctrl       = '{init: 1'b0, step: rd_pend_r, data: rd_data_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt      = S_OUT;
        res_status_nxt = ST_OK;
        res_crc_nxt    = '0;
        unique case (item_r.mode)
          MODE_META: begin
            if (item_r.version != link_version_r) begin
              res_status_nxt = ST_BAD_VERSION;
            end else if ({1'b0, item_r.file_bytes} > BUF_LIMIT) begin
              open_nxt       = 1'b0;
              res_status_nxt = ST_TOO_LARGE;
            end else begin
              open_nxt       = 1'b1;
              open_file_nxt  = item_r.file_id;
              open_size_nxt  = SW'(item_r.file_bytes);
              announced_nxt  = item_r.chunk_count;
              received_nxt   = '0;
              sender_crc_nxt = item_r.expected_crc;
              res_status_nxt = open_r ? ST_REPLACED : ST_OK;
            end
          end
          MODE_CHUNK: begin
            if (item_r.version != link_version_r) begin
              res_status_nxt = ST_BAD_VERSION;
            end else if (!open_r || (item_r.file_id != open_file_r)) begin
              res_status_nxt = ST_ORPHAN;
            end else if (chunk_end_addr > XW'(open_size_r)) begin
              res_status_nxt = ST_RANGE;
            end else begin
              mem_we = (item_r.byte_offset < item_r.chunk_length);
              if (item_r.chunk_end) begin
                received_nxt = received_r + 16'd1;
              end
            end
          end
          MODE_DONE: begin
            if (!open_r) begin
              res_status_nxt = ST_IDLE_DONE;
            end else begin
              open_nxt = 1'b0;
              if (received_r == announced_r) begin
                state_nxt     = S_CRC;
                rd_addr_nxt   = '0;
                crc_ctrl.init = 1'b1;
              end else begin
                res_status_nxt = ST_INCOMPLETE;
              end
            end
          end
          MODE_NOP: begin
            res_status_nxt = ST_OK;
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
      end
      S_CRC: begin
        // Issue one read per cycle; the unit folds each byte in the following cycle
        if (rd_addr_r < open_size_r) begin
          rd_addr_nxt = rd_addr_r + SW'(1);
          rd_pend_nxt = 1'b1;
        end else if (!rd_pend_r) begin
          state_nxt      = S_OUT;
          res_crc_nxt    = crc_value;
          res_status_nxt = (crc_value == sender_crc_r) ? ST_CRC_OK : ST_CRC_BAD;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load on finish, drop on take
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      link_version_r <= LINK_VERSION_RST;
      open_r         <= 1'b0;
      open_file_r    <= '0;
      open_size_r    <= '0;
      announced_r    <= '0;
      received_r     <= '0;
      sender_crc_r   <= '0;
      rd_pend_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      open_r       <= open_nxt;
      open_file_r  <= open_file_nxt;
      open_size_r  <= open_size_nxt;
      announced_r  <= announced_nxt;
      received_r   <= received_nxt;
      sender_crc_r <= sender_crc_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        link_version_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
    if (state_r == S_MUL) begin
      base_r <= BW'(item_r.chunk_index) * CHUNK_K;
    end
    rd_addr_r    <= rd_addr_nxt;
    res_status_r <= res_status_nxt;
    res_crc_r    <= res_crc_nxt;
    if (out_load) begin
      out_r <= '{status:           res_status_r,
                 computed_crc:     res_crc_r,
                 current_file:     open_file_r,
                 chunks_seen:      received_r,
                 chunks_announced: announced_r};
    end
  end

  // File buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr[AW-1:0]] <= item_r.data_byte;
    end
    rd_data_r <= mem[rd_addr_r[AW-1:0]];
  end

  crcc_crc_unit u_crc (
    .clk  (clk),
    .ctrl (crc_ctrl),
    .crc  (crc_value)
  );

endmodule

### tb/tb_chunk_reassembly_crc_check.sv
// Self-checking testbench for chunk_reassembly_crc_check: directed and random requests
// with valid/ready idling, checked against an in-bench prediction of the transfer state.
// Depends on crcc_pkg and the chunk_reassembly_crc_check RTL.
`timescale 1ns / 1ps

module tb_chunk_reassembly_crc_check;
  import crcc_pkg::*;

  localparam logic [31:0] BUF_BYTES   = 32'd65536;
  localparam logic [31:0] CHUNK_BYTES = 32'd240;
  localparam int          RANDOM_REQUESTS = 1900;

  typedef logic [7:0] byte_q_t [$];
  typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_DROP, FLAW_DUP, FLAW_STRAY} flaw_t;
  typedef enum int {
    STRAY_ID, STRAY_VERSION, STRAY_META_VERSION, STRAY_RANGE, STRAY_OFFSET, STRAY_NOP
  } stray_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [7:0] cfg_data;

  // Predicted block state
  logic [7:0]  link_ver = LINK_VERSION_RST;
  bit          xfer_open = 1'b0;
  logic [31:0] xfer_id = '0;
  logic [16:0] xfer_size = '0;
  logic [15:0] xfer_announced = '0;
  logic [15:0] xfer_received = '0;
  logic [31:0] xfer_crc = '0;
  int          xfer_gen = 0;
  logic [7:0]  file_mem [0:BUF_BYTES-1];
  int          mem_gen [0:BUF_BYTES-1];

  out_item_t transfer_reports [$];

  // Run bookkeeping
  int  fail_count = 0;
  int  requests_sent = 0;
  int  reports_checked = 0;
  int  crc_ok_count = 0;
  int  crc_bad_count = 0;
  int  incomplete_count = 0;
  bit  pace_on = 1'b1;
  int  burst_left = 0;
  bit  rx_random = 1'b1;
  int  rx_hold_left = 0;
  int  rx_run_left = 0;
  bit  rx_level = 1'b1;

  chunk_reassembly_crc_check dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Hard limit on run time
  initial begin
    #60_000_000;
    $display("chunk_reassembly_crc_check: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Standard reflected CRC-32 over a byte sequence
  function automatic logic [31:0] crc32_bytes(input byte_q_t data);
    logic [31:0] c;
    c = CRC_INIT;
    foreach (data[i]) begin
      c ^= {24'd0, data[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

  // Advance the predicted transfer state by one request and form its report
  task automatic model_transfer_step(input in_item_t req, output out_item_t res);
    logic [31:0] base;
    logic [31:0] addr;
    logic [3:0]  st;
    logic [31:0] crc;
    bit          was_open;
    byte_q_t     span;
    st = ST_OK;
    crc = '0;
    case (req.mode)
      MODE_META: begin
        if (req.version != link_ver) begin
          st = ST_BAD_VERSION;
        end else begin
          was_open = xfer_open;
          xfer_open = 1'b0;
          if (req.file_bytes > BUF_BYTES) begin
            st = ST_TOO_LARGE;
          end else begin
            xfer_open = 1'b1;
            xfer_id = req.file_id;
            xfer_size = req.file_bytes[16:0];
            xfer_announced = req.chunk_count;
            xfer_received = '0;
            xfer_crc = req.expected_crc;
            xfer_gen++;
            st = was_open ? ST_REPLACED : ST_OK;
          end
        end
      end
      MODE_CHUNK: begin
        if (req.version != link_ver) begin
          st = ST_BAD_VERSION;
        end else if (!xfer_open || req.file_id != xfer_id) begin
          st = ST_ORPHAN;
        end else begin
          base = {16'd0, req.chunk_index} * CHUNK_BYTES;
          if (base + {24'd0, req.chunk_length} > {15'd0, xfer_size}) begin
            st = ST_RANGE;
          end else begin
            // store only offsets inside the chunk; chunk_end counts regardless
            if (req.byte_offset < req.chunk_length) begin
              addr = base + {24'd0, req.byte_offset};
              file_mem[addr] = req.data_byte;
              mem_gen[addr] = xfer_gen;
            end
            if (req.chunk_end) xfer_received++;
          end
        end
      end
      MODE_DONE: begin
        if (!xfer_open) begin
          st = ST_IDLE_DONE;
        end else begin
          if (xfer_received == xfer_announced) begin
            for (int a = 0; a < xfer_size; a++) span.push_back(file_mem[a]);
            crc = crc32_bytes(span);
            st = (crc == xfer_crc) ? ST_CRC_OK : ST_CRC_BAD;
            if (st == ST_CRC_OK) crc_ok_count++;
            else crc_bad_count++;
          end else begin
            st = ST_INCOMPLETE;
            incomplete_count++;
          end
          xfer_open = 1'b0;
        end
      end
      default: ;
    endcase
    res.status = st;
    res.computed_crc = crc;
    res.current_file = xfer_id;
    res.chunks_seen = xfer_received;
    res.chunks_announced = xfer_announced;
  endtask

  // A complete done must never hash bytes left over from an earlier transfer
  function automatic bit done_hits_stale_bytes();
    if (!xfer_open || xfer_received != xfer_announced) return 1'b0;
    for (int a = 0; a < xfer_size; a++) begin
      if (mem_gen[a] != xfer_gen) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic in_item_t blank_request(input logic [1:0] mode);
    in_item_t r;
    r = '0;
    r.mode = mode;
    r.version = link_ver;
    return r;
  endfunction

  function automatic in_item_t meta_request(input logic [31:0] id, input logic [31:0] size,
                                            input logic [15:0] chunks, input logic [31:0] crc);
    in_item_t r;
    r = blank_request(MODE_META);
    r.file_id = id;
    r.file_bytes = size;
    r.chunk_count = chunks;
    r.expected_crc = crc;
    return r;
  endfunction

  function automatic in_item_t chunk_request(input logic [31:0] id, input logic [15:0] idx,
                                             input logic [7:0] len, input logic [7:0] off,
                                             input logic [7:0] data, input logic last);
    in_item_t r;
    r = blank_request(MODE_CHUNK);
    r.file_id = id;
    r.chunk_index = idx;
    r.chunk_length = len;
    r.byte_offset = off;
    r.data_byte = data;
    r.chunk_end = last;
    return r;
  endfunction

  // Offer one request, hold it until taken, then predict and pace
  task automatic push_request(input in_item_t req);
    out_item_t want;
    int gap;
    in_valid <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (!in_ready);
    model_transfer_step(req, want);
    transfer_reports.push_back(want);
    requests_sent++;
    if (pace_on) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  // Before a done that would hash stale bytes, count one empty chunk so it stays incomplete
  task automatic send_request(input in_item_t req);
    if (req.mode == MODE_DONE && done_hits_stale_bytes())
      push_request(chunk_request(xfer_id, 16'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    push_request(req);
  endtask

  // Drop valid and wait until every predicted report has come back
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (transfer_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_link_version(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    link_ver = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One request that a well-formed transfer should shrug off
  function automatic in_item_t stray_request(input logic [31:0] id);
    in_item_t r;
    stray_t   kind;
    kind = stray_t'($urandom_range(0, 5));
    r = chunk_request(id, 16'd0, 8'd0, 8'($urandom), 8'($urandom), 1'b0);
    case (kind)
      STRAY_ID:           r.file_id = id ^ (32'd1 << $urandom_range(0, 31));
      STRAY_VERSION:      r.version = link_ver ^ 8'($urandom_range(1, 255));
      STRAY_META_VERSION: begin
        r = meta_request($urandom, $urandom_range(0, 500), 16'($urandom), $urandom);
        r.version = link_ver ^ 8'($urandom_range(1, 255));
      end
      STRAY_RANGE:        r.chunk_index = 16'($urandom_range(300, 65535));
      STRAY_OFFSET:       r.byte_offset = 8'($urandom_range(1, 255));
      default:            r = blank_request(MODE_NOP);
    endcase
    return r;
  endfunction

  // Meta, the chunk bytes in some order, then done
  task automatic send_transfer(input logic [31:0] id, input int size, input flaw_t flaw);
    byte_q_t     pay;
    int          order [$];
    logic [31:0] crc;
    int          nchunks;
    int          c;
    int          len;
    int          j;
    int          t;
    for (int k = 0; k < size; k++) pay.push_back(8'($urandom));
    crc = crc32_bytes(pay);
    if (flaw == FLAW_CRC) crc ^= 32'd1 << $urandom_range(0, 31);
    nchunks = (size + CHUNK_BYTES - 1) / CHUNK_BYTES;
    send_request(meta_request(id, size, 16'(nchunks), crc));
    for (int k = 0; k < nchunks; k++) order.push_back(k);
    if (flaw == FLAW_DROP && nchunks > 0) order.delete($urandom_range(0, nchunks - 1));
    if (flaw == FLAW_DUP && nchunks > 0) order.push_back($urandom_range(0, nchunks - 1));
    // shuffle chunk order half the time
    if ($urandom_range(0, 1) == 1) begin
      for (int k = order.size() - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = order[k];
        order[k] = order[j];
        order[j] = t;
      end
    end
    foreach (order[i]) begin
      c = order[i];
      len = (size - c * CHUNK_BYTES > CHUNK_BYTES) ? CHUNK_BYTES : size - c * CHUNK_BYTES;
      for (int b = 0; b < len; b++) begin
        if (flaw == FLAW_STRAY && $urandom_range(0, 7) == 0) send_request(stray_request(id));
        send_request(chunk_request(id, 16'(c), 8'(len), 8'(b), pay[c * CHUNK_BYTES + b],
                                   b == len - 1));
      end
    end
    send_request(blank_request(MODE_DONE));
  endtask

  // Fully random request, biased toward the open transfer
  function automatic in_item_t random_request();
    logic [191:0] bits;
    in_item_t     r;
    int           pick;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = bits[$bits(in_item_t)-1:0];
    pick = $urandom_range(0, 19);
    if (pick < 3) r.mode = MODE_META;
    else if (pick < 14) r.mode = MODE_CHUNK;
    else if (pick < 17) r.mode = MODE_DONE;
    else r.mode = MODE_NOP;
    if ($urandom_range(0, 6) != 0) r.version = link_ver;
    if (r.mode == MODE_META) begin
      case ($urandom_range(0, 5))
        0, 1: r.file_bytes = $urandom_range(0, 480);
        2:    r.file_bytes = $urandom_range(0, BUF_BYTES);
        3:    r.file_bytes = BUF_BYTES;
        4:    r.file_bytes = BUF_BYTES + 1;
        default: ;
      endcase
      if ($urandom_range(0, 3) != 0) r.chunk_count = 16'($urandom_range(0, 3));
      if ($urandom_range(0, 3) != 0) r.file_id = {31'd0, 1'($urandom)};
    end else if (r.mode == MODE_CHUNK) begin
      if ($urandom_range(0, 4) != 0) r.file_id = xfer_id;
      if ($urandom_range(0, 3) != 0) r.chunk_index = 16'($urandom_range(0, 2));
      if ($urandom_range(0, 2) != 0) begin
        r.chunk_length = 8'($urandom_range(0, CHUNK_BYTES));
        if (r.chunk_length != 0) r.byte_offset = 8'($urandom_range(0, r.chunk_length - 1));
      end
    end
    return r;
  endfunction

  // Compare each accepted report with the oldest prediction
  always @(posedge clk) begin : check_reports
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      reports_checked++;
      if (transfer_reports.size() == 0) begin
        report_mismatch($sformatf("report with none pending: status %0d file %h",
                                  out_item.status, out_item.current_file));
      end else begin
        want = transfer_reports.pop_front();
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_item.status, want.status));
        if (out_item.computed_crc !== want.computed_crc)
          report_mismatch($sformatf("computed_crc %h, want %h",
                                    out_item.computed_crc, want.computed_crc));
        if (out_item.current_file !== want.current_file)
          report_mismatch($sformatf("current_file %h, want %h",
                                    out_item.current_file, want.current_file));
        if (out_item.chunks_seen !== want.chunks_seen)
          report_mismatch($sformatf("chunks_seen %0d, want %0d",
                                    out_item.chunks_seen, want.chunks_seen));
        if (out_item.chunks_announced !== want.chunks_announced)
          report_mismatch($sformatf("chunks_announced %0d, want %0d",
                                    out_item.chunks_announced, want.chunks_announced));
      end
    end
  end

  // Receiver: long holds on request, otherwise runs of ready and stall
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (!rx_random) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        rx_level = ($urandom_range(0, 2) != 0);
        if (rx_level) rx_run_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 20);
        else rx_run_left = $urandom_range(1, 9);
      end
      rx_run_left--;
      out_ready <= rx_level;
    end
  end

  // Edge values of every field and every status
  task automatic test_directed();
    in_item_t    r;
    byte_q_t     pay;
    logic [31:0] crc;
    r = blank_request(MODE_DONE);
    r.version = 8'hA5;
    send_request(r);
    r = '1;
    r.mode = MODE_NOP;
    send_request(r);
    send_request(chunk_request(32'd1, 16'd0, 8'd1, 8'd0, 8'hFF, 1'b1));
    r = meta_request(32'd3, 32'd4, 16'd1, 32'd0);
    r.version = ~link_ver;
    send_request(r);
    send_request(meta_request(32'd3, BUF_BYTES + 1, 16'd1, 32'd0));
    send_request(meta_request(32'hFFFF_FFFF, BUF_BYTES, 16'hFFFF, 32'hFFFF_FFFF));
    // oversize closes the open transfer, so its chunks become orphans
    send_request(meta_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_request(chunk_request(32'hFFFF_FFFF, 16'd0, 8'd1, 8'd0, 8'h00, 1'b1));
    send_request(meta_request(32'hFFFF_FFFF, BUF_BYTES, 16'd7, 32'd0));
    // five-byte file replaces the open one
    for (int k = 0; k < 5; k++) pay.push_back(8'($urandom));
    crc = crc32_bytes(pay);
    send_request(meta_request(32'd0, 32'd5, 16'd1, crc));
    send_request(chunk_request(32'd1, 16'd0, 8'd5, 8'd0, 8'h55, 1'b0));
    r = chunk_request(32'd0, 16'd0, 8'd5, 8'd0, 8'h55, 1'b0);
    r.version = link_ver ^ 8'h80;
    send_request(r);
    send_request(chunk_request(32'd0, 16'hFFFF, 8'd0, 8'd0, 8'hAA, 1'b1));
    send_request(chunk_request(32'd0, 16'd0, 8'd6, 8'd0, 8'hAA, 1'b1));
    send_request(chunk_request(32'd0, 16'd0, 8'd5, 8'hFF, 8'hAA, 1'b0));
    for (int k = 0; k < 5; k++)
      send_request(chunk_request(32'd0, 16'd0, 8'd5, 8'(k), pay[k], k == 4));
    r = blank_request(MODE_DONE);
    r.version = 8'hFF;
    send_request(r);
    // empty file closed by one zero-length chunk
    send_request(meta_request(32'd7, 32'd0, 16'd1, 32'd0));
    send_request(chunk_request(32'd7, 16'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    send_request(blank_request(MODE_DONE));
    // wrong CRC, then a short count
    send_transfer(32'h8000_0001, 3, FLAW_CRC);
    send_request(meta_request(32'd9, 32'd2, 16'd2, 32'd0));
    send_request(blank_request(MODE_DONE));
    drain_reports();
  endtask

  // Version register at both extremes and a random value
  task automatic test_link_versions();
    logic [7:0] settings [3];
    settings = '{8'h00, 8'hFF, 8'($urandom)};
    foreach (settings[i]) begin
      write_link_version(settings[i]);
      send_transfer($urandom, $urandom_range(1, 60), FLAW_STRAY);
      send_transfer($urandom, $urandom_range(1, 30), FLAW_NONE);
      drain_reports();
    end
  endtask

  // Mostly well-formed transfers with random content and some flaws
  task automatic test_file_transfers(input int stop_at);
    flaw_t flaw;
    int    size;
    while (requests_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0:       flaw = FLAW_CRC;
        1:       flaw = FLAW_DROP;
        2:       flaw = FLAW_DUP;
        3, 4:    flaw = FLAW_STRAY;
        default: flaw = FLAW_NONE;
      endcase
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(241, 720) : $urandom_range(0, 100);
      send_transfer($urandom, size, flaw);
    end
    drain_reports();
  endtask

  task automatic test_random_requests(input int count);
    repeat (count) send_request(random_request());
    drain_reports();
  endtask

  // Hold the receiver while the sender keeps offering, then pause until drained
  task automatic test_backpressure();
    pace_on = 1'b0;
    rx_hold_left = 200;
    send_transfer($urandom, $urandom_range(20, 40), FLAW_NONE);
    pace_on = 1'b1;
    drain_reports();
    send_transfer($urandom, $urandom_range(5, 30), FLAW_NONE);
    drain_reports();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_link_versions();
    write_link_version(8'($urandom));
    test_file_transfers(RANDOM_REQUESTS - 400);
    write_link_version(LINK_VERSION_RST);
    test_random_requests(350);
    test_backpressure();

    $display("run covered %0d requests and %0d reports checked", requests_sent,
             reports_checked);
    $display("transfers closed: %0d CRC good, %0d CRC bad, %0d short or over count",
             crc_ok_count, crc_bad_count, incomplete_count);
    if (fail_count == 0) begin
      $display("chunk_reassembly_crc_check: match");
    end else begin
      $display("chunk_reassembly_crc_check: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
sv/crcc_pkg.sv
sv/crcc_crc_unit.sv
sv/chunk_reassembly_crc_check.sv
tb/tb_chunk_reassembly_crc_check.sv
